@@ src/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

@@ src/bitrd_pkg.sv @@
// types and constants of the msb-first bit reader
`default_nettype none

package bitrd_pkg;

   localparam int BYTE_BITS       = 8;
   localparam int MAX_READ_BITS   = 32;
   localparam int MAX_FETCH_BYTES = 5;
   localparam int ACC_W           = MAX_FETCH_BYTES * BYTE_BITS;
   localparam int COUNT_W         = 6;
   localparam int FETCH_W         = 3;
   localparam int VALUE_W         = 32;
   localparam int AVAIL_W         = 16;
   localparam logic [AVAIL_W-1:0] AVAIL_MAX = 16'hFFFF;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_LOAD  = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   typedef enum logic [1:0] {
      OP_START,
      OP_LOAD,
      OP_READ,
      OP_BAD
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [BYTE_BITS-1:0] byte_value;
      logic [COUNT_W-1:0]   bit_count;
      logic                 too_long;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

@@ src/bitrd_req_if.sv @@
// request channel: one word per item
`default_nettype none

interface bitrd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] byte_value;
   logic [5:0] bit_count;

   modport source (output valid, kind, byte_value, bit_count, input ready);
   modport sink   (input valid, kind, byte_value, bit_count, output ready);
endinterface

`default_nettype wire

@@ src/bitrd_rsp_if.sv @@
// response channel: one word per item
`default_nettype none

interface bitrd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] value;
   logic        error;
   logic [15:0] bits_available;

   modport source (output valid, value, error, bits_available, input ready);
   modport sink   (input valid, value, error, bits_available, output ready);
endinterface

`default_nettype wire

@@ src/bitrd_ram.sv @@
// generic single-write, single-read ram with registered read data
`default_nettype none

module bitrd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ src/bitrd_front.sv @@
// front end: takes request words and decodes them into commands
`default_nettype none

module bitrd_front (
   bitrd_req_if.sink          req_ch,
   output logic               push_valid,
   input  wire logic          push_ready,
   output bitrd_pkg::cmd_type push_cmd
);

   assign push_valid = req_ch.valid;
   assign req_ch.ready = push_ready;

   always_comb begin
      push_cmd.byte_value = req_ch.byte_value;
      push_cmd.bit_count  = req_ch.bit_count;
      push_cmd.too_long   =
         req_ch.bit_count > bitrd_pkg::COUNT_W'(bitrd_pkg::MAX_READ_BITS);
      case (req_ch.kind)
         bitrd_pkg::KIND_START: push_cmd.op = bitrd_pkg::OP_START;
         bitrd_pkg::KIND_LOAD:  push_cmd.op = bitrd_pkg::OP_LOAD;
         bitrd_pkg::KIND_READ:  push_cmd.op = bitrd_pkg::OP_READ;
         default:               push_cmd.op = bitrd_pkg::OP_BAD;
      endcase
   end

endmodule

`default_nettype wire

@@ src/bitrd_queue.sv @@
// short command queue between front end and back end
`default_nettype none

module bitrd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire bitrd_pkg::cmd_type in_cmd,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output bitrd_pkg::cmd_type      out_cmd
);

   localparam int DEPTH = bitrd_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bitrd_pkg::cmd_type slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push, pop;

   assign in_ready  = count_ff != CNT_W'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_cmd   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

`default_nettype wire

@@ src/bitrd_back.sv @@
// back end: buffer state, byte fetch sequencer and response register
`default_nettype none

module bitrd_back #(
   parameter int BUFFER_BYTES = 4096
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            cmd_valid,
   output logic                                 cmd_ready,
   input  wire bitrd_pkg::cmd_type              cmd,
   output logic                                 ram_wr_en,
   output logic [$clog2(BUFFER_BYTES)-1:0]      ram_wr_addr,
   output logic [bitrd_pkg::BYTE_BITS-1:0]      ram_wr_data,
   output logic                                 ram_rd_en,
   output logic [$clog2(BUFFER_BYTES)-1:0]      ram_rd_addr,
   input  wire logic [bitrd_pkg::BYTE_BITS-1:0] ram_rd_data,
   bitrd_rsp_if.source                          rsp_ch
);

   localparam int AW = $clog2(BUFFER_BYTES);
   localparam int TW = $clog2(BUFFER_BYTES + 1);
   localparam int PW = TW + 3;
   localparam int UW = (PW > bitrd_pkg::AVAIL_W) ? PW : bitrd_pkg::AVAIL_W + 1;
   localparam int CW = bitrd_pkg::COUNT_W;
   localparam int FW = bitrd_pkg::FETCH_W;
   localparam int VW = bitrd_pkg::VALUE_W;

   bitrd_pkg::state_type state_ff, state_in;

   logic [TW-1:0]                total_ff, total_in;
   logic [PW-1:0]                pos_ff, pos_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [FW-1:0]                nbytes_ff, nbytes_in;
   logic [FW-1:0]                issued_ff, issued_in;
   logic [FW-1:0]                recv_ff, recv_in;
   logic [2:0]                   shift_ff, shift_in;
   logic                         rd_pend_ff, rd_pend_in;
   logic [bitrd_pkg::ACC_W-1:0]  acc_ff, acc_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]                 rsp_value_ff;
   logic                          rsp_error_ff;
   logic [bitrd_pkg::AVAIL_W-1:0] rsp_avail_ff;

   logic                          out_free, pop, load_out, read_ok;
   logic [VW-1:0]                 res_value;
   logic                          res_error;
   logic [PW-1:0]                 unread_now, unread_next;
   logic [UW-1:0]                 unread_now_w, unread_next_w;
   logic [bitrd_pkg::AVAIL_W-1:0] avail_next;
   logic [CW-1:0]                 span, span_up;
   logic [TW-1:0]                 fetch_byte;
   logic [bitrd_pkg::ACC_W-1:0]   acc_shifted;
   logic [VW:0]                   mask;

   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign cmd_ready = (state_ff == bitrd_pkg::ST_IDLE) && out_free;
   assign pop       = cmd_valid && cmd_ready;

   assign unread_now   = {total_ff, 3'b000} - pos_ff;
   assign unread_now_w = UW'(unread_now);
   assign read_ok      = !cmd.too_long && (UW'(cmd.bit_count) <= unread_now_w);

   // bytes touched by a read and the right shift that aligns its last bit
   assign span    = CW'(pos_ff[2:0]) + cmd.bit_count;
   assign span_up = span + CW'(7);

   assign fetch_byte  = pos_ff[PW-1:3] + TW'(issued_ff);
   assign acc_shifted = acc_ff >> shift_ff;
   assign mask        = ((VW + 1)'(1) << count_ff) - (VW + 1)'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bitrd_pkg::ST_IDLE: begin
            if (pop && cmd.op == bitrd_pkg::OP_READ && read_ok && cmd.bit_count != '0) begin
               state_in = bitrd_pkg::ST_FETCH;
            end
         end
         bitrd_pkg::ST_FETCH: begin
            if (rd_pend_ff && FW'(recv_ff + 1'b1) == nbytes_ff) begin
               state_in = bitrd_pkg::ST_FINISH;
            end
         end
         bitrd_pkg::ST_FINISH: state_in = bitrd_pkg::ST_IDLE;
         default:              state_in = bitrd_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      total_in    = total_ff;
      pos_in      = pos_ff;
      count_in    = count_ff;
      nbytes_in   = nbytes_ff;
      issued_in   = issued_ff;
      recv_in     = recv_ff;
      shift_in    = shift_ff;
      rd_pend_in  = 1'b0;
      acc_in      = acc_ff;
      load_out    = 1'b0;
      res_value   = '0;
      res_error   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = total_ff[AW-1:0];
      ram_wr_data = cmd.byte_value;
      ram_rd_en   = 1'b0;
      ram_rd_addr = fetch_byte[AW-1:0];
      case (state_ff)
         bitrd_pkg::ST_IDLE: begin
            if (pop) begin
               case (cmd.op)
                  bitrd_pkg::OP_START: begin
                     total_in = '0;
                     pos_in   = '0;
                     load_out = 1'b1;
                  end
                  bitrd_pkg::OP_LOAD: begin
                     load_out = 1'b1;
                     if (total_ff < TW'(BUFFER_BYTES)) begin
                        ram_wr_en = 1'b1;
                        total_in  = total_ff + 1'b1;
                     end else begin
                        res_error = 1'b1;
                     end
                  end
                  bitrd_pkg::OP_READ: begin
                     if (!read_ok) begin
                        res_error = 1'b1;
                        load_out  = 1'b1;
                     end else if (cmd.bit_count == '0) begin
                        load_out = 1'b1;
                     end else begin
                        count_in  = cmd.bit_count;
                        nbytes_in = span_up[5:3];
                        shift_in  = ~span[2:0] + 3'd1;
                        issued_in = '0;
                        recv_in   = '0;
                        acc_in    = '0;
                     end
                  end
                  default: begin
                     res_error = 1'b1;
                     load_out  = 1'b1;
                  end
               endcase
            end
         end
         bitrd_pkg::ST_FETCH: begin
            if (issued_ff != nbytes_ff) begin
               ram_rd_en  = 1'b1;
               issued_in  = issued_ff + 1'b1;
               rd_pend_in = 1'b1;
            end
            if (rd_pend_ff) begin
               acc_in  = {acc_ff[bitrd_pkg::ACC_W-bitrd_pkg::BYTE_BITS-1:0], ram_rd_data};
               recv_in = recv_ff + 1'b1;
            end
         end
         bitrd_pkg::ST_FINISH: begin
            res_value = acc_shifted[VW-1:0] & mask[VW-1:0];
            pos_in    = pos_ff + PW'(count_ff);
            load_out  = 1'b1;
         end
         default: ;
      endcase
   end

   // bits still unread once this item is done, clipped to the field
   assign unread_next   = {total_in, 3'b000} - pos_in;
   assign unread_next_w = UW'(unread_next);
   assign avail_next    = (unread_next_w > UW'(bitrd_pkg::AVAIL_MAX)) ?
                          bitrd_pkg::AVAIL_MAX : unread_next_w[bitrd_pkg::AVAIL_W-1:0];

   assign rsp_valid_in = load_out ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bitrd_pkg::ST_IDLE;
         total_ff     <= '0;
         pos_ff       <= '0;
         issued_ff    <= '0;
         recv_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         pos_ff       <= pos_in;
         issued_ff    <= issued_in;
         recv_ff      <= recv_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      count_ff  <= count_in;
      nbytes_ff <= nbytes_in;
      shift_ff  <= shift_in;
      acc_ff    <= acc_in;
      if (load_out) begin
         rsp_value_ff <= res_value;
         rsp_error_ff <= res_error;
         rsp_avail_ff <= avail_next;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.value          = rsp_value_ff;
   assign rsp_ch.error          = rsp_error_ff;
   assign rsp_ch.bits_available = rsp_avail_ff;

endmodule

`default_nettype wire

@@ src/msb_first_bit_reader_core.sv @@
// path: start, load and refused words pass the command queue and response register;
//   a read of n stored bytes (n = 1 to 5) also passes the fetch and finish states
// throughput: 1 word per cycle for start and load while responses are taken; a read
//   holds off later words while the store's single read port fetches a byte per cycle
// reset: synchronous, clears buffer length, read position, queue and response valid;
//   the byte store itself is not cleared and is read only where loaded
`default_nettype none

module msb_first_bit_reader_core #(
   parameter int BUFFER_BYTES = 4096
) (
   input  wire logic   clock,
   input  wire logic   reset,
   bitrd_req_if.sink   req_ch,
   bitrd_rsp_if.source rsp_ch
);

   localparam int AW = $clog2(BUFFER_BYTES);

   // front end to queue
   logic               push_valid, push_ready;
   bitrd_pkg::cmd_type push_cmd;

   // queue to back end
   logic               cmd_valid, cmd_ready;
   bitrd_pkg::cmd_type cmd;

   // byte store ports
   logic                           ram_wr_en, ram_rd_en;
   logic [AW-1:0]                  ram_wr_addr, ram_rd_addr;
   logic [bitrd_pkg::BYTE_BITS-1:0] ram_wr_data, ram_rd_data;

   // decode the request word into a command
   bitrd_front u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   // decouples request acceptance from the byte fetch sequencer
   bitrd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_cmd    (push_cmd),
      .out_valid (cmd_valid),
      .out_ready (cmd_ready),
      .out_cmd   (cmd)
   );

   // buffer state, reads spanning byte boundaries, response register
   bitrd_back #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .cmd         (cmd),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_ch      (rsp_ch)
   );

   // byte store, one byte written per load, one byte read per fetch cycle
   bitrd_ram #(
      .WIDTH (bitrd_pkg::BYTE_BITS),
      .DEPTH (BUFFER_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

`default_nettype wire

@@ src/bitrd_checker.sv @@
// port-level checks of the bit reader, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module bitrd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_value,
   input wire logic        rsp_error,
   input wire logic [15:0] rsp_bits_available
);

   // words accepted and not yet answered
   logic [2:0] pend_ff, pend_in;
   logic       req_take, rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   always_comb begin
      pend_in = pend_ff;
      if (req_take && !rsp_take) begin
         pend_in = pend_ff + 1'b1;
      end else if (rsp_take && !req_take) begin
         pend_in = pend_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
   `ASSERT_NOW(a_error_zero, clock, reset, rsp_valid && rsp_error, rsp_value == 32'd0, "refused word carries data")
   `ASSERT_NOW(a_no_orphan, clock, reset, rsp_valid, pend_ff != 3'd0, "response without a pending word")
   `ASSERT_NEXT(a_stall_keeps_avail, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_bits_available), "bit count changed while stalled")

endmodule

bind msb_first_bit_reader_core bitrd_checker u_bitrd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_value          (rsp_ch.value),
   .rsp_error          (rsp_ch.error),
   .rsp_bits_available (rsp_ch.bits_available)
);

`default_nettype wire

@@ sim/tb_msb_first_bit_reader_core.sv @@
// self-checking testbench for the msb-first bit reader core
`timescale 1ns / 1ps

module tb_msb_first_bit_reader_core;

   localparam int          BUFFER_BYTES    = 4096;
   localparam int          WATCHDOG_CYCLES = 1000;
   localparam int          DRAIN_CYCLES    = 16;
   localparam int          RANDOM_WORDS    = 420;
   localparam int          QUIET_TAIL      = 120;
   localparam int          FILL_BYTES      = 64;
   localparam int          MAX_REPORTS     = 10;
   // the one kind code that the block has no meaning for
   localparam logic [1:0]  KIND_UNUSED     = 2'd3;

   typedef struct packed {
      logic [bitrd_pkg::VALUE_W-1:0] value;
      logic                          error;
      logic [bitrd_pkg::AVAIL_W-1:0] bits_available;
   } reader_rsp_type;

   // tracks the reader state and checks every response word in order
   class bitstream_scoreboard;
      logic [bitrd_pkg::BYTE_BITS-1:0] byte_copy[];
      int unsigned          store_depth;
      int unsigned          bytes_loaded;
      int unsigned          read_bit_pos;
      reader_rsp_type       pending_rsp[$];
      int                   failures;
      int                   n_start, n_load, n_read, n_refused, n_unused;
      int unsigned          peak_avail;

      function new(int unsigned depth);
         store_depth = depth;
         byte_copy   = new[depth];
      endfunction

      function int unsigned unread_bits();
         int unsigned stop_pos;
         stop_pos = bytes_loaded * bitrd_pkg::BYTE_BITS;
         return (stop_pos > read_bit_pos) ? stop_pos - read_bit_pos : 0;
      endfunction

      function void flag(string msg);
         failures++;
         if (failures <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
      endfunction

      // predict the response of one accepted request word
      function void note_word(logic [1:0] kind, logic [7:0] byte_value,
                              logic [5:0] bit_count);
         reader_rsp_type rsp;
         int unsigned avail, pos;
         rsp = '0;
         case (kind)
            bitrd_pkg::KIND_START: begin
               n_start++;
               bytes_loaded = 0;
               read_bit_pos = 0;
            end
            bitrd_pkg::KIND_LOAD: begin
               n_load++;
               if (bytes_loaded < store_depth) begin
                  byte_copy[bytes_loaded] = byte_value;
                  bytes_loaded++;
               end else begin
                  rsp.error = 1'b1;
               end
            end
            bitrd_pkg::KIND_READ: begin
               n_read++;
               if (bit_count > bitrd_pkg::MAX_READ_BITS || bit_count > unread_bits()) begin
                  rsp.error = 1'b1;
                  n_refused++;
               end else begin
                  for (int i = 0; i < bit_count; i++) begin
                     pos = read_bit_pos + i;
                     rsp.value = {rsp.value[bitrd_pkg::VALUE_W-2:0],
                                  byte_copy[pos / bitrd_pkg::BYTE_BITS]
                                           [bitrd_pkg::BYTE_BITS - 1 -
                                            pos % bitrd_pkg::BYTE_BITS]};
                  end
                  read_bit_pos += bit_count;
               end
            end
            default: begin
               n_unused++;
               rsp.error = 1'b1;
            end
         endcase
         avail = unread_bits();
         if (avail > peak_avail) peak_avail = avail;
         rsp.bits_available = (avail > bitrd_pkg::AVAIL_MAX) ? bitrd_pkg::AVAIL_MAX
                                                            : avail[bitrd_pkg::AVAIL_W-1:0];
         pending_rsp.push_back(rsp);
      endfunction

      function void check_word(logic [31:0] value, logic error, logic [15:0] avail);
         reader_rsp_type exp_rsp;
         if (pending_rsp.size() == 0) begin
            flag($sformatf("response with nothing expected: value %h error %b avail %0d",
                           value, error, avail));
            return;
         end
         exp_rsp = pending_rsp.pop_front();
         if (value !== exp_rsp.value || error !== exp_rsp.error ||
             avail !== exp_rsp.bits_available)
            flag($sformatf({"mismatch: value %h/%h error %b/%b bits_available %0d/%0d",
                            " (expected/actual)"},
                           exp_rsp.value, value, exp_rsp.error, error,
                           exp_rsp.bits_available, avail));
      endfunction
   endclass

   logic clock;
   logic reset;

   bitrd_req_if req_if ();
   bitrd_rsp_if rsp_if ();

   msb_first_bit_reader_core #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if)
   );

   bitstream_scoreboard sb;
   bit                  req_gaps_on;
   bit                  rsp_stalls_on;
   int                  words_sent;
   int                  quiet_cycles;

   // free-running 100 MHz clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response side: ready low in random bursts while stalls are enabled
   initial begin
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_stalls_on && $urandom_range(0, 7) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // response monitor and watchdog; both sample the values seen at the edge
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_word(rsp_if.value, rsp_if.error, rsp_if.bits_available);
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_CYCLES);
            $display("FAIL");
            $finish;
         end
      end
   end

   // drive one request word, with an optional idle burst first
   task automatic send_word(input logic [1:0] kind, input logic [7:0] byte_value,
                            input logic [5:0] bit_count);
      if (req_gaps_on && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.kind       <= kind;
      req_if.byte_value <= byte_value;
      req_if.bit_count  <= bit_count;
      // the word moves at the first edge that sees ready high
      do @(posedge clock); while (!req_if.ready);
      sb.note_word(kind, byte_value, bit_count);
      words_sent++;
   endtask

   // unused fields get random content so every input bit toggles
   task automatic start_buffer();
      send_word(bitrd_pkg::KIND_START, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
   endtask

   task automatic load_byte(input logic [7:0] b);
      send_word(bitrd_pkg::KIND_LOAD, b, 6'($urandom_range(0, 63)));
   endtask

   task automatic read_bits(input logic [5:0] n);
      send_word(bitrd_pkg::KIND_READ, 8'($urandom_range(0, 255)), n);
   endtask

   task automatic unused_kind();
      send_word(KIND_UNUSED, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
   endtask

   // mostly well-formed buffers (start, loads, reads that fit), some noise
   task automatic run_random_words(input int target);
      int          stop_at;
      int unsigned avail;
      stop_at = words_sent + target;
      while (words_sent < stop_at) begin
         if (words_sent >= stop_at - QUIET_TAIL) begin
            // no idling at all in the last stretch
            req_gaps_on   = 1'b0;
            rsp_stalls_on = 1'b0;
         end else begin
            req_gaps_on   = ($urandom_range(0, 3) != 0);
            rsp_stalls_on = ($urandom_range(0, 3) != 0);
         end
         if ($urandom_range(0, 99) < 10) begin
            avail = sb.unread_bits();
            case ($urandom_range(0, 2))
               0: unused_kind();
               1: read_bits(6'($urandom_range(33, 63)));
               default: begin
                  // just past what is left, or over the length limit
                  if (avail < bitrd_pkg::MAX_READ_BITS)
                     read_bits(6'($urandom_range(avail + 1, bitrd_pkg::MAX_READ_BITS)));
                  else
                     read_bits(6'($urandom_range(33, 63)));
               end
            endcase
         end else begin
            start_buffer();
            repeat ($urandom_range(0, 12)) load_byte(8'($urandom_range(0, 255)));
            repeat ($urandom_range(1, 8)) begin
               avail = sb.unread_bits();
               if ($urandom_range(0, 4) == 0)
                  load_byte(8'($urandom_range(0, 255)));
               else
                  read_bits(6'($urandom_range(0, (avail > bitrd_pkg::MAX_READ_BITS)
                                                 ? bitrd_pkg::MAX_READ_BITS : avail)));
            end
         end
      end
   endtask

   initial begin
      sb                = new(BUFFER_BYTES);
      words_sent        = 0;
      quiet_cycles      = 0;
      req_gaps_on       = 1'b1;
      rsp_stalls_on     = 1'b1;
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.kind       <= bitrd_pkg::KIND_START;
      req_if.byte_value <= '0;
      req_if.bit_count  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty reader, then byte patterns at the extremes
      read_bits(0);
      read_bits(1);
      unused_kind();
      start_buffer();
      load_byte(8'hFF);
      load_byte(8'h00);
      load_byte(8'hA5);
      load_byte(8'h5A);
      load_byte(8'h81);
      load_byte(8'h7E);
      read_bits(0);
      read_bits(1);
      read_bits(7);
      read_bits(32);
      read_bits(33);
      read_bits(63);
      read_bits(8);
      // position now sits at the end of the buffer
      read_bits(1);
      read_bits(0);
      unused_kind();
      // an unaligned full-width read spanning five bytes
      start_buffer();
      repeat (5) load_byte(8'($urandom_range(0, 255)));
      read_bits(3);
      read_bits(32);

      // a longer buffer read down in random pieces until reads are refused
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b1;
      start_buffer();
      repeat (FILL_BYTES) load_byte(8'($urandom_range(0, 255)));
      read_bits(0);
      read_bits(33);
      req_gaps_on = 1'b1;
      repeat (40) read_bits(6'($urandom_range(0, bitrd_pkg::MAX_READ_BITS)));

      run_random_words(RANDOM_WORDS);
      req_if.valid <= 1'b0;

      // drain: every expected word, then an idle stretch before the summary
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d words: %0d starts, %0d loads, %0d reads (%0d refused), %0d unused",
               words_sent, sb.n_start, sb.n_load, sb.n_read, sb.n_refused, sb.n_unused);
      $display("a %0d-byte buffer read down to refusal; peak unread bits %0d; %0d failures",
               FILL_BYTES, sb.peak_avail, sb.failures + sb.pending_rsp.size());
      if (sb.failures == 0 && sb.pending_rsp.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ msb_first_bit_reader_core.f @@
+incdir+src
src/bitrd_pkg.sv
src/bitrd_req_if.sv
src/bitrd_rsp_if.sv
src/bitrd_ram.sv
src/bitrd_front.sv
src/bitrd_queue.sv
src/bitrd_back.sv
src/msb_first_bit_reader_core.sv
src/bitrd_checker.sv
sim/tb_msb_first_bit_reader_core.sv
